@@ src/glos_pkg.sv @@
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants of the grid line-of-sight engine.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Default grid limits and position format
  localparam int MAX_COLS_DEF  = 64;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 8;

  // Position width: start coordinate plus a ray offset of up to 17 bits
  localparam int PW  = 19;
  // Cell coordinate width, wide enough for the smallest fraction size
  localparam int CLW = 15;

  // Blocking cell codes
  localparam logic [7:0] CODE_WALL = 8'h23;
  localparam logic [7:0] CODE_DOOR = 8'h44;

  // Register reset values
  localparam logic [6:0] WIDTH_RST  = 7'd64;
  localparam logic [6:0] HEIGHT_RST = 7'd64;
  localparam logic [7:0] RADIUS_RST = 8'd64;
  localparam logic [7:0] STEP_RST   = 8'd20;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LOS   = 2'd2,
    OP_MOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_STEP   = 2'd3
  } reg_idx_t;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CORNER = 13'b0000000000010,
    ST_PROBE  = 13'b0000000000100,
    ST_CHECK  = 13'b0000000001000,
    ST_SQX    = 13'b0000000010000,
    ST_SQY    = 13'b0000000100000,
    ST_SQS    = 13'b0000001000000,
    ST_SQRT   = 13'b0000010000000,
    ST_MUL    = 13'b0000100000000,
    ST_DVLD   = 13'b0001000000000,
    ST_DIV    = 13'b0010000000000,
    ST_MPOS   = 13'b0100000000000,
    ST_MSTEP  = 13'b1000000000000
  } state_t;

endpackage

@@ src/grid_line_of_sight_engine_unit.sv @@
// ----------------------------------------------------------------------------
// grid_line_of_sight_engine_unit
// Tile grid of 8-bit cell codes with cell access, collision and
// line-of-sight queries.
// ----------------------------------------------------------------------------
// Usage: each beat on s_* is one query, s_tuser selects write cell, read
// cell, line of sight or can-move. Every query returns exactly one beat on
// m_* (cell code read and verdict). The cfg channel writes the map size,
// body radius and march step; the user must write them only while the
// block is idle, which the block does not enforce; it is always ready.
// A write takes the PROBE state; a read takes PROBE and CHECK; can-move
// makes up to four corner probes (CORNER, PROBE, CHECK each) through the
// single grid memory port. Line of sight with coinciding points answers
// at once; otherwise it runs a setup (two squares, a 17-step square root,
// two 24-step divides, all on one multiplier), then passes MPOS, PROBE,
// CHECK and MSTEP for each ray sample, about length/march_step samples.
// One query is in flight at a time: s_tready is low from acceptance until
// the result beat is taken. A stalled receiver holds the result in the
// output register and no new query is taken. Reset clears control state
// and restores register defaults; the grid contents are undefined until
// written.
// ----------------------------------------------------------------------------
module grid_line_of_sight_engine_unit #(
  parameter int MAX_COLS  = glos_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = glos_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = glos_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,    // op
  input  logic [87:0] s_tdata,    // cell_col, cell_row, cell_code, from_x,
                                  // from_y, to_x, to_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // cell_read, verdict, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = $clog2(MAX_COLS + 1);
  localparam int RB    = $clog2(MAX_ROWS + 1);
  localparam int PW    = glos_pkg::PW;
  localparam int CLW   = glos_pkg::CLW;

  // Configuration registers
  logic [6:0] map_width, map_height;
  logic [7:0] body_radius, march_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= glos_pkg::WIDTH_RST;
      map_height  <= glos_pkg::HEIGHT_RST;
      body_radius <= glos_pkg::RADIUS_RST;
      march_step  <= glos_pkg::STEP_RST;
    end else if (cfg_valid) begin
      case (glos_pkg::reg_idx_t'(cfg_index))
        glos_pkg::REG_WIDTH:  map_width   <= cfg_data[6:0];
        glos_pkg::REG_HEIGHT: map_height  <= cfg_data[6:0];
        glos_pkg::REG_RADIUS: body_radius <= cfg_data;
        glos_pkg::REG_STEP:   march_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective map size and step
  logic [CB-1:0] eff_w;
  logic [RB-1:0] eff_h;
  logic [7:0]    eff_step;

  always_comb begin
    if (map_width == '0)                         eff_w = CB'(1);
    else if ({2'b0, map_width} > 9'(MAX_COLS))   eff_w = CB'(MAX_COLS);
    else                                         eff_w = CB'({2'b0, map_width});
    if (map_height == '0)                        eff_h = RB'(1);
    else if ({2'b0, map_height} > 9'(MAX_ROWS))  eff_h = RB'(MAX_ROWS);
    else                                         eff_h = RB'({2'b0, map_height});
    eff_step = (march_step == '0) ? 8'd1 : march_step;
  end

  // Sequencer and datapath registers
  glos_pkg::state_t state;
  glos_pkg::op_t    op;
  logic signed [15:0] fx, fy;
  logic        dx_neg, dy_neg;
  logic [15:0] ax, ay;
  logic [7:0]  code;
  logic [CLW-1:0] probe_col, probe_row;
  logic [1:0]  corner;
  logic        axis;
  logic [4:0]  cnt;
  logic [31:0] prod, acc;
  logic [33:0] sq_n;
  logic [18:0] sq_rem;
  logic [16:0] sq_root;
  logic [23:0] dv_num;
  logic [16:0] dv_rem;
  logic [16:0] len;
  logic [17:0] t;
  logic [24:0] qx, qy;
  logic [17:0] rx, ry;
  logic [23:0] qix, qiy;
  logic [16:0] rix, riy;
  logic        off_map;
  logic [7:0]  mem_q;

  // Input beat unpacking
  logic [7:0]  in_col, in_row, in_code;
  logic signed [15:0] in_fx, in_fy, in_tx, in_ty;
  logic signed [16:0] in_dx, in_dy;
  logic        in_same;
  assign in_col  = s_tdata[7:0];
  assign in_row  = s_tdata[15:8];
  assign in_code = s_tdata[23:16];
  assign in_fx   = s_tdata[39:24];
  assign in_fy   = s_tdata[55:40];
  assign in_tx   = s_tdata[71:56];
  assign in_ty   = s_tdata[87:72];
  assign in_dx   = 17'(in_tx) - 17'(in_fx);
  assign in_dy   = 17'(in_ty) - 17'(in_fy);
  // line of sight between coinciding points answers visible at once
  assign in_same = (glos_pkg::op_t'(s_tuser) == glos_pkg::OP_LOS) &&
                   (in_dx == '0) && (in_dy == '0);

  assign s_tready = (state == glos_pkg::ST_IDLE) && !m_tvalid;

  // Shared multiplier, operands chosen by state
  logic [15:0] mul_a, mul_b;
  always_comb begin
    case (state)
      glos_pkg::ST_SQX: begin mul_a = ax; mul_b = ax; end
      glos_pkg::ST_SQY: begin mul_a = ay; mul_b = ay; end
      default: begin
        mul_a = axis ? ay : ax;
        mul_b = {8'd0, eff_step};
      end
    endcase
  end

  // Grid address of the probe cell
  logic          on_map;
  logic [RB+CB-1:0] lin;
  logic [AW-1:0] addr;
  always_comb begin
    on_map = !probe_col[CLW-1] && !probe_row[CLW-1] &&
             (probe_col < CLW'(eff_w)) && (probe_row < CLW'(eff_h));
    lin  = (RB+CB)'(probe_row[RB-1:0]) * (RB+CB)'(eff_w) +
           (RB+CB)'(probe_col[CB-1:0]);
    addr = lin[AW-1:0];
  end

  // Grid memory, one port
  logic [7:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (state == glos_pkg::ST_PROBE) begin
      if (op == glos_pkg::OP_WRITE && on_map) mem[addr] <= code;
      mem_q <= mem[addr];
    end
  end

  // Probe positions: corner of the body square or current ray sample
  logic signed [PW-1:0] px, py, rr, cx, cy, mx, my, fl_x, fl_y, sel_x, sel_y;
  always_comb begin
    px = PW'(fx);
    py = PW'(fy);
    rr = PW'({1'b0, body_radius});
    cx = corner[0] ? px + rr : px - rr;
    cy = corner[1] ? py + rr : py - rr;
    mx = dx_neg ? px - PW'({1'b0, qx[16:0]}) : px + PW'({1'b0, qx[16:0]});
    my = dy_neg ? py - PW'({1'b0, qy[16:0]}) : py + PW'({1'b0, qy[16:0]});
    sel_x = (state == glos_pkg::ST_CORNER) ? cx : mx;
    sel_y = (state == glos_pkg::ST_CORNER) ? cy : my;
    fl_x = sel_x >>> FRAC_BITS;
    fl_y = sel_y >>> FRAC_BITS;
  end

  // Square root and divide steps
  logic [20:0] sq_sh, sq_trial;
  logic [17:0] dv_sh;
  logic        dv_ge;
  always_comb begin
    sq_sh    = {sq_rem, sq_n[33:32]};
    sq_trial = {2'b0, sq_root, 2'b01};
    dv_sh    = {dv_rem, dv_num[23]};
    dv_ge    = dv_sh >= {1'b0, len};
  end

  // March step update
  logic [17:0] t_nx, rx_sum, ry_sum;
  always_comb begin
    t_nx   = t + 18'(eff_step);
    rx_sum = rx + 18'(rix);
    ry_sum = ry + 18'(riy);
  end

  // Cell code seen by the probe
  logic [7:0] seen;
  logic       blocked;
  assign seen    = off_map ? glos_pkg::CODE_WALL : mem_q;
  assign blocked = (seen == glos_pkg::CODE_WALL) || (seen == glos_pkg::CODE_DOOR);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= glos_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        glos_pkg::ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op        <= glos_pkg::op_t'(s_tuser);
            code      <= in_code;
            fx        <= in_fx;
            fy        <= in_fy;
            dx_neg    <= in_dx[16];
            dy_neg    <= in_dy[16];
            ax        <= in_dx[16] ? 16'(-in_dx) : in_dx[15:0];
            ay        <= in_dy[16] ? 16'(-in_dy) : in_dy[15:0];
            probe_col <= CLW'($signed(in_col));
            probe_row <= CLW'($signed(in_row));
            corner    <= 2'd0;
            axis      <= 1'b0;
            m_tdata   <= {7'd0, in_same, 8'd0};
            case (glos_pkg::op_t'(s_tuser))
              glos_pkg::OP_WRITE, glos_pkg::OP_READ: state <= glos_pkg::ST_PROBE;
              glos_pkg::OP_MOVE: state <= glos_pkg::ST_CORNER;
              default: begin
                if (in_same) begin
                  m_tvalid <= 1'b1;
                end else begin
                  state <= glos_pkg::ST_SQX;
                end
              end
            endcase
          end
        end
        glos_pkg::ST_CORNER, glos_pkg::ST_MPOS: begin
          probe_col <= fl_x[CLW-1:0];
          probe_row <= fl_y[CLW-1:0];
          state     <= glos_pkg::ST_PROBE;
        end
        glos_pkg::ST_PROBE: begin
          off_map <= !on_map;
          if (op == glos_pkg::OP_WRITE) begin
            m_tvalid <= 1'b1;
            state    <= glos_pkg::ST_IDLE;
          end else begin
            state <= glos_pkg::ST_CHECK;
          end
        end
        glos_pkg::ST_CHECK: begin
          if (op == glos_pkg::OP_READ) begin
            m_tdata[7:0] <= seen;
            m_tvalid     <= 1'b1;
            state        <= glos_pkg::ST_IDLE;
          end else if (blocked) begin
            m_tvalid <= 1'b1;
            state    <= glos_pkg::ST_IDLE;
          end else if (op == glos_pkg::OP_MOVE) begin
            if (corner == 2'd3) begin
              m_tdata[8] <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= glos_pkg::ST_IDLE;
            end else begin
              corner <= corner + 2'd1;
              state  <= glos_pkg::ST_CORNER;
            end
          end else begin
            state <= glos_pkg::ST_MSTEP;
          end
        end
        glos_pkg::ST_SQX: begin
          prod  <= mul_a * mul_b;
          state <= glos_pkg::ST_SQY;
        end
        glos_pkg::ST_SQY: begin
          acc   <= prod;
          prod  <= mul_a * mul_b;
          state <= glos_pkg::ST_SQS;
        end
        glos_pkg::ST_SQS: begin
          sq_n    <= 34'(acc) + 34'(prod);
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          state   <= glos_pkg::ST_SQRT;
        end
        glos_pkg::ST_SQRT: begin
          // one root bit per cycle
          if (sq_sh >= sq_trial) begin
            sq_rem  <= 19'(sq_sh - sq_trial);
            sq_root <= {sq_root[15:0], 1'b1};
          end else begin
            sq_rem  <= sq_sh[18:0];
            sq_root <= {sq_root[15:0], 1'b0};
          end
          sq_n <= {sq_n[31:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            len   <= (sq_sh >= sq_trial) ? {sq_root[15:0], 1'b1}
                                         : {sq_root[15:0], 1'b0};
            state <= glos_pkg::ST_MUL;
          end
        end
        glos_pkg::ST_MUL: begin
          prod  <= mul_a * mul_b;
          state <= glos_pkg::ST_DVLD;
        end
        glos_pkg::ST_DVLD: begin
          dv_num <= prod[23:0];
          dv_rem <= '0;
          cnt    <= '0;
          state  <= glos_pkg::ST_DIV;
        end
        glos_pkg::ST_DIV: begin
          // restoring divide of magnitude*step by length, one bit a cycle
          dv_rem <= dv_ge ? 17'(dv_sh - {1'b0, len}) : dv_sh[16:0];
          dv_num <= {dv_num[22:0], dv_ge};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            if (!axis) begin
              qix   <= {dv_num[22:0], dv_ge};
              rix   <= dv_ge ? 17'(dv_sh - {1'b0, len}) : dv_sh[16:0];
              axis  <= 1'b1;
              state <= glos_pkg::ST_MUL;
            end else begin
              qiy   <= {dv_num[22:0], dv_ge};
              riy   <= dv_ge ? 17'(dv_sh - {1'b0, len}) : dv_sh[16:0];
              t     <= '0;
              qx    <= '0;
              qy    <= '0;
              rx    <= '0;
              ry    <= '0;
              state <= glos_pkg::ST_MPOS;
            end
          end
        end
        glos_pkg::ST_MSTEP: begin
          t <= t_nx;
          if (rx_sum >= {1'b0, len}) begin
            rx <= rx_sum - {1'b0, len};
            qx <= qx + 25'(qix) + 25'd1;
          end else begin
            rx <= rx_sum;
            qx <= qx + 25'(qix);
          end
          if (ry_sum >= {1'b0, len}) begin
            ry <= ry_sum - {1'b0, len};
            qy <= qy + 25'(qiy) + 25'd1;
          end else begin
            ry <= ry_sum;
            qy <= qy + 25'(qiy);
          end
          if (t_nx >= {1'b0, len}) begin
            m_tdata[8] <= 1'b1;
            m_tvalid   <= 1'b1;
            state      <= glos_pkg::ST_IDLE;
          end else begin
            state <= glos_pkg::ST_MPOS;
          end
        end
        default: state <= glos_pkg::ST_IDLE;
      endcase
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != glos_pkg::ST_IDLE || m_tvalid))
    else $error("accepted query produced neither work nor result");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("ready while a result is pending");

  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == '0 || !m_tdata[8]))
    else $error("cell read and verdict both set");

  a_march_inside_ray: assert property (@(posedge clk) disable iff (rst)
    (state == glos_pkg::ST_MPOS) |-> (t < {1'b0, len}))
    else $error("ray sample beyond ray length");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid line-of-sight engine. A map is loaded
// first, then directed and random cell, collision and ray queries run under
// several register settings. Each result beat is checked against a local
// prediction of the grid, the collision square and the ray march.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NCOLS        = 64;
  localparam int  NROWS        = 64;
  // loaded area; every map size used keeps width*height within it
  localparam int  LOAD_W       = 16;
  localparam int  LOAD_H       = 8;
  localparam longint CYCLE_CAP = 50_000_000;
  localparam logic [7:0] CODE_FLOOR = 8'h2E;

  typedef struct {
    glos_pkg::op_t     op;
    logic signed [7:0] col;
    logic signed [7:0] row;
    logic [7:0]        code;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
  } query_t;

  typedef struct {
    logic [7:0] cell_read;
    logic       verdict;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // mirror of the grid and registers
  logic [7:0]  grid_mirror [NCOLS*NROWS];
  logic [6:0]  w_reg;
  logic [6:0]  h_reg;
  logic [7:0]  r_reg;
  logic [7:0]  s_reg;

  answer_t     pending_answers[$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  longint      cycles = 0;

  grid_line_of_sight_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- prediction ----------------
  function automatic longint eff_w();
    if (w_reg == 0) return 1;
    return (w_reg > NCOLS) ? NCOLS : longint'(w_reg);
  endfunction

  function automatic longint eff_h();
    if (h_reg == 0) return 1;
    return (h_reg > NROWS) ? NROWS : longint'(h_reg);
  endfunction

  function automatic bit on_grid(longint c, longint r);
    return c >= 0 && r >= 0 && c < eff_w() && r < eff_h();
  endfunction

  function automatic int grid_addr(longint c, longint r);
    return int'((r * eff_w() + c) % (NCOLS*NROWS));
  endfunction

  function automatic logic [7:0] tile_at(longint c, longint r);
    if (!on_grid(c, r)) return glos_pkg::CODE_WALL;
    return grid_mirror[grid_addr(c, r)];
  endfunction

  function automatic bit solid_at(longint x, longint y);
    logic [7:0] t;
    t = tile_at(x >>> 8, y >>> 8);
    return t == glos_pkg::CODE_WALL || t == glos_pkg::CODE_DOOR;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint ray_part(longint d, longint unsigned t, longint unsigned len);
    longint unsigned mag, q;
    mag = longint'(unsigned'((d < 0) ? -d : d));
    q = mag * t / len;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit sight_clear(longint fx, longint fy, longint tx, longint ty);
    longint dx, dy;
    longint unsigned ax, ay, len, t, stp;
    dx = tx - fx;
    dy = ty - fy;
    if (dx == 0 && dy == 0) return 1'b1;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    stp = (s_reg == 0) ? 64'd1 : 64'(s_reg);
    len = int_sqrt(ax*ax + ay*ay);
    for (t = 0; t < len; t += stp)
      if (solid_at(fx + ray_part(dx, t, len), fy + ray_part(dy, t, len))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit body_free(longint px, longint py);
    longint r;
    r = longint'(r_reg);
    return !solid_at(px - r, py - r) && !solid_at(px + r, py - r) &&
           !solid_at(px - r, py + r) && !solid_at(px + r, py + r);
  endfunction

  function automatic answer_t answer_for(query_t q);
    answer_t a;
    a.cell_read = 8'd0;
    a.verdict   = 1'b0;
    case (q.op)
      glos_pkg::OP_WRITE:
        if (on_grid(q.col, q.row)) grid_mirror[grid_addr(q.col, q.row)] = q.code;
      glos_pkg::OP_READ: a.cell_read = tile_at(q.col, q.row);
      glos_pkg::OP_LOS:  a.verdict = sight_clear(q.fx, q.fy, q.tx, q.ty);
      default:           a.verdict = body_free(q.fx, q.fy);
    endcase
    return a;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    answer_t exp_a;
    int n;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        exp_a = pending_answers.pop_front();
        if (m_tdata[7:0] !== exp_a.cell_read || m_tdata[8] !== exp_a.verdict) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: cell_read exp %h got %h, verdict exp %b got %b",
                     exp_a.cell_read, m_tdata[7:0], exp_a.verdict, m_tdata[8]);
        end
      end
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        m_tready   <= 1'b0;
        stall_left <= n;
      end
    end else if (!m_tready) begin
      if (stall_left <= 1) begin
        m_tready   <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_query(query_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= q.op;
    s_tdata  <= {q.ty, q.tx, q.fy, q.fx, q.code, q.row, q.col};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pending_answers.push_back(answer_for(q));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(glos_pkg::reg_idx_t idx, logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      glos_pkg::REG_WIDTH:  w_reg = val[6:0];
      glos_pkg::REG_HEIGHT: h_reg = val[6:0];
      glos_pkg::REG_RADIUS: r_reg = val;
      default:              s_reg = val;
    endcase
  endtask

  function automatic query_t noise_query();
    query_t q;
    q.op   = glos_pkg::op_t'($urandom_range(0, 3));
    q.col  = 8'($urandom);
    q.row  = 8'($urandom);
    q.code = 8'($urandom);
    q.fx   = 16'($urandom);
    q.fy   = 16'($urandom);
    q.tx   = 16'($urandom);
    q.ty   = 16'($urandom);
    return q;
  endfunction

  // mostly floor with scattered blockers and odd codes
  function automatic logic [7:0] pick_code();
    int k;
    k = $urandom_range(0, 99);
    if (k < 6) return glos_pkg::CODE_WALL;
    if (k < 9) return glos_pkg::CODE_DOOR;
    if (k < 18) begin
      pick_code = 8'($urandom);
      if (pick_code == glos_pkg::CODE_WALL || pick_code == glos_pkg::CODE_DOOR)
        pick_code = CODE_FLOOR;
      return pick_code;
    end
    return CODE_FLOOR;
  endfunction

  function automatic logic signed [15:0] grid_pos(longint cells);
    return 16'($urandom_range(0, int'(cells)*256 + 255)) - 16'sd128;
  endfunction

  // well-formed query with random content
  function automatic query_t shaped_query();
    query_t q;
    int k, span;
    q = noise_query();
    k = $urandom_range(0, 99);
    q.fx = grid_pos(eff_w());
    q.fy = grid_pos(eff_h());
    if (k < 15) begin
      q.op   = glos_pkg::OP_WRITE;
      q.col  = 8'($urandom_range(0, int'(eff_w()) - 1));
      q.row  = 8'($urandom_range(0, int'(eff_h()) - 1));
      q.code = pick_code();
    end else if (k < 35) begin
      q.op  = glos_pkg::OP_READ;
      q.col = 8'($urandom_range(0, int'(eff_w())) - int'($urandom_range(0, 9) == 0));
      q.row = 8'($urandom_range(0, int'(eff_h())) - int'($urandom_range(0, 9) == 0));
    end else if (k < 70) begin
      q.op = glos_pkg::OP_LOS;
      span = (s_reg < 8) ? 4*256 : (($urandom_range(0, 3) == 0) ? 64*256 : 12*256);
      q.tx = q.fx + 16'($urandom_range(0, 2*span)) - 16'(span);
      q.ty = q.fy + 16'($urandom_range(0, 2*span)) - 16'(span);
      if ($urandom_range(0, 19) == 0) begin
        q.tx = q.fx;
        q.ty = q.fy;
      end
    end else begin
      q.op = glos_pkg::OP_MOVE;
    end
    return q;
  endfunction

  // ---------------- tests ----------------
  task automatic test_load_map();
    query_t q;
    write_reg(glos_pkg::REG_WIDTH, 8'(LOAD_W));
    write_reg(glos_pkg::REG_HEIGHT, 8'(LOAD_H));
    no_idle = 1'b1;
    for (int r = 0; r < LOAD_H; r++)
      for (int c = 0; c < LOAD_W; c++) begin
        q = noise_query();
        q.op   = glos_pkg::OP_WRITE;
        q.col  = 8'(c);
        q.row  = 8'(r);
        q.code = pick_code();
        send_query(q);
      end
    no_idle = 1'b0;
  endtask

  task automatic test_directed();
    query_t q;
    q = noise_query();
    // reads at grid corners and just off them
    q.op = glos_pkg::OP_READ;
    q.col = 8'sd0;    q.row = 8'sd0;    send_query(q);
    q.col = 8'sd15;   q.row = 8'sd7;    send_query(q);
    q.col = 8'sd16;   q.row = 8'sd0;    send_query(q);
    q.col = 8'sd0;    q.row = -8'sd1;   send_query(q);
    q.col = -8'sd128; q.row = 8'sd127;  send_query(q);
    q.col = 8'sd127;  q.row = -8'sd128; send_query(q);
    // off-map write is dropped; an on-map write is read back and restored to floor
    q.op = glos_pkg::OP_WRITE; q.col = -8'sd1; q.row = 8'sd5; q.code = 8'hFF; send_query(q);
    q.op = glos_pkg::OP_WRITE; q.col = 8'sd5;  q.row = 8'sd5; q.code = 8'h00; send_query(q);
    q.op = glos_pkg::OP_READ;  send_query(q);
    q.op = glos_pkg::OP_WRITE; q.code = CODE_FLOOR; send_query(q);
    // coinciding points, short ray, position extremes, then can-move probes
    q.op = glos_pkg::OP_LOS; q.fx = 16'sh0480; q.fy = 16'sh0380; q.tx = q.fx; q.ty = q.fy;
    send_query(q);
    q.tx = 16'sh0A00; send_query(q);
    q.fx = -16'sd32768; q.fy = 16'sh7FFF; q.tx = 16'sh7FFF; q.ty = -16'sd32768; send_query(q);
    q.fx = 16'sh0180; q.fy = 16'sh0180; q.tx = 16'sh7FFF; q.ty = 16'sh0180; send_query(q);
    q.op = glos_pkg::OP_MOVE; q.fx = 16'sh0800; q.fy = 16'sh0400; send_query(q);
    q.fx = 16'sh2000; q.fy = 16'sh2000; send_query(q);
    q.fx = -16'sd32768; send_query(q);
    q.fx = 16'sh7FFF; q.fy = 16'sh7FFF; send_query(q);
    q.fx = 16'sh0040; q.fy = 16'sh0040; send_query(q);
  endtask

  task automatic test_reg_extremes();
    query_t q;
    write_reg(glos_pkg::REG_RADIUS, 8'd0);
    write_reg(glos_pkg::REG_STEP, 8'd0);
    q = noise_query();
    q.op = glos_pkg::OP_MOVE; q.fx = 16'sh0000; q.fy = 16'sh0000; send_query(q);
    q.op = glos_pkg::OP_LOS;  q.fx = 16'sh0280; q.fy = 16'sh0180;
    q.tx = 16'sh0B00; q.ty = 16'sh0500;
    send_query(q);
    write_reg(glos_pkg::REG_RADIUS, 8'd255);
    write_reg(glos_pkg::REG_STEP, 8'd255);
    q.op = glos_pkg::OP_MOVE; q.fx = 16'sh0880; q.fy = 16'sh0480; send_query(q);
    q.op = glos_pkg::OP_LOS;  q.tx = 16'sh3F00; q.ty = 16'sh0100; send_query(q);
    write_reg(glos_pkg::REG_WIDTH, 8'd0);
    write_reg(glos_pkg::REG_HEIGHT, 8'hFF);
    q.op = glos_pkg::OP_READ; q.col = 8'sd0; q.row = 8'sd70; send_query(q);
    q.row = 8'sd63; send_query(q);
    q.col = 8'sd1; send_query(q);
    write_reg(glos_pkg::REG_WIDTH, 8'd1);
    write_reg(glos_pkg::REG_HEIGHT, 8'd1);
    q.col = 8'sd0; q.row = 8'sd0; send_query(q);
    q.op = glos_pkg::OP_MOVE; q.fx = 16'sh0080; q.fy = 16'sh0080; send_query(q);
  endtask

  task automatic test_random_phases();
    // sizes stay within the loaded cells, with width clamping to 64 and a zero height read as 1
    logic [7:0] wv [5] = '{8'd16, 8'd127, 8'd17, 8'd2, 8'd40};
    logic [7:0] hv [5] = '{8'd8, 8'd2, 8'd7, 8'd128, 8'd3};
    logic [7:0] rv [5] = '{8'd64, 8'd200, 8'd0, 8'd128, 8'd255};
    logic [7:0] sv [5] = '{8'd20, 8'd8, 8'd255, 8'd100, 8'd3};
    for (int p = 0; p < 5; p++) begin
      write_reg(glos_pkg::REG_WIDTH, wv[p] ^ {1'($urandom_range(0, 1)), 7'd0});
      write_reg(glos_pkg::REG_HEIGHT, hv[p]);
      write_reg(glos_pkg::REG_RADIUS, rv[p]);
      write_reg(glos_pkg::REG_STEP, sv[p]);
      no_idle = (p == 2);
      for (int i = 0; i < 80; i++)
        send_query(($urandom_range(0, 9) == 0) ? noise_query() : shaped_query());
    end
    no_idle = 1'b0;
  endtask

  // ---------------- main sequence ----------------
  initial begin
    w_reg = glos_pkg::WIDTH_RST;
    h_reg = glos_pkg::HEIGHT_RST;
    r_reg = glos_pkg::RADIUS_RST;
    s_reg = glos_pkg::STEP_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_map();
    test_directed();
    test_reg_extremes();
    test_random_phases();
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
